FILE: src/tcrt_pkg.sv
// ---------------------------------------------------------------------------
// tcrt_pkg
// Types and constants shared by the reload timer and its channels.
// ---------------------------------------------------------------------------
`default_nettype none

package tcrt_pkg;

    localparam int unsigned MAX_CHANNELS = 3;
    localparam int unsigned DIV_COUNT    = 5;
    localparam int unsigned PRE_WIDTH    = 10;
    localparam int unsigned TCR_WIDTH    = 10;
    localparam int unsigned DATA_WIDTH   = 32;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register map, word addresses
    localparam logic [3:0] ADDR_TOCR    = 4'd0;
    localparam logic [3:0] ADDR_TSTR    = 4'd1;
    localparam int unsigned ADDR_CH_BASE = 2;
    localparam int unsigned ADDR_CH_STEP = 3;
    localparam int unsigned KIND_TCOR    = 0;
    localparam int unsigned KIND_TCNT    = 1;
    localparam int unsigned KIND_TCR     = 2;

    // control register fields
    localparam int unsigned UNF_POS  = 8;
    localparam int unsigned UNIE_POS = 5;
    localparam logic [2:0] TPSC_MAX  = 3'd4;
    localparam logic [TCR_WIDTH-1:0] TCR_FLAGS        = 10'h300;
    localparam logic [TCR_WIDTH-1:0] TCR_MASK_CAPTURE = 10'h3ff;
    localparam logic [TCR_WIDTH-1:0] TCR_MASK_PLAIN   = 10'h13f;

    // prescaler masks for divide by 4, 16, 64, 256, 1024
    localparam logic [PRE_WIDTH-1:0] DIV_MASK [DIV_COUNT] = '{
        10'h003, 10'h00f, 10'h03f, 10'h0ff, 10'h3ff
    };

    typedef struct packed {
        logic [1:0]            opcode;
        logic [3:0]            reg_address;
        logic [DATA_WIDTH-1:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]   read_data;
        logic [MAX_CHANNELS-1:0] irq_lines;
    } rsp_item_t;

    typedef struct packed {
        logic                  tick;
        logic                  start;
        logic [DIV_COUNT-1:0]  div_edge;
        logic                  wr_tcor;
        logic                  wr_tcnt;
        logic                  wr_tcr;
        logic [DATA_WIDTH-1:0] wr_data;
    } chan_ctl_t;

endpackage

`default_nettype wire

FILE: src/tcrt_channel.sv
// ---------------------------------------------------------------------------
// tcrt_channel
// One down-counting channel: constant, count and control registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tcrt_channel
    import tcrt_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter bit          HAS_CAPTURE = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  chan_ctl_t              ctl,
    output logic [COUNT_WIDTH-1:0] tcor,
    output logic [COUNT_WIDTH-1:0] tcnt,
    output logic [TCR_WIDTH-1:0]   tcr,
    output logic                   irq
);

    localparam logic [TCR_WIDTH-1:0] TCR_MASK =
        HAS_CAPTURE ? TCR_MASK_CAPTURE : TCR_MASK_PLAIN;

    logic [COUNT_WIDTH-1:0] tcor_reg, tcor_next;
    logic [COUNT_WIDTH-1:0] tcnt_reg, tcnt_next;
    logic [TCR_WIDTH-1:0]   tcr_reg, tcr_next;
    logic [2:0]             tpsc;
    logic                   run;
    logic                   underflow;

    assign tpsc      = tcr_reg[2:0];
    assign run       = ctl.tick && ctl.start && (tpsc <= TPSC_MAX) && ctl.div_edge[tpsc];
    assign underflow = run && (tcnt_reg == '0);

    always_comb
    begin
        tcor_next = tcor_reg;
        tcnt_next = tcnt_reg;
        tcr_next  = tcr_reg;
        if (ctl.wr_tcor)
        begin
            tcor_next = ctl.wr_data[COUNT_WIDTH-1:0];
        end
        if (ctl.wr_tcnt)
        begin
            tcnt_next = ctl.wr_data[COUNT_WIDTH-1:0];
        end
        else if (underflow)
        begin
            tcnt_next = tcor_reg;
        end
        else if (run)
        begin
            tcnt_next = tcnt_reg - 1'b1;
        end
        // flags are only cleared by a write of zero
        if (ctl.wr_tcr)
        begin
            tcr_next = ((ctl.wr_data[TCR_WIDTH-1:0] & ~TCR_FLAGS)
                       | (tcr_reg & ctl.wr_data[TCR_WIDTH-1:0] & TCR_FLAGS)) & TCR_MASK;
        end
        else if (underflow)
        begin
            tcr_next[UNF_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcor_reg <= '1;
            tcnt_reg <= '1;
            tcr_reg  <= '0;
        end
        else
        begin
            tcor_reg <= tcor_next;
            tcnt_reg <= tcnt_next;
            tcr_reg  <= tcr_next;
        end
    end

    assign tcor = tcor_reg;
    assign tcnt = tcnt_reg;
    assign tcr  = tcr_reg;
    // interrupt reflects the state after this transaction
    assign irq  = tcr_next[UNF_POS] & tcr_next[UNIE_POS];

endmodule

`default_nettype wire

FILE: src/three_channel_reload_timer.sv
// ---------------------------------------------------------------------------
// three_channel_reload_timer
// Three down-counting reload timers with prescaler and register access.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  request | req_valid | req_stall | req: opcode, reg_address, write_data
//  result  | rsp_valid | rsp_stall | rsp: read_data, irq_lines
//
//  one transaction per cycle while req_stall is low; an accepted transaction moves
//  through the input register, then the result register, where rsp_valid rises,
//  and the result can be taken from there when the result side is free
//  all timer state updates as the transaction moves from input to result register
//  asynchronous reset clears the pipeline, counters to all ones, control to zero
//  req_stall rises only while the input register is full and the result is stalled
// ---------------------------------------------------------------------------
`default_nettype none

module three_channel_reload_timer
    import tcrt_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = 3,
    parameter int unsigned COUNT_WIDTH   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam logic [MAX_CHANNELS-1:0] START_MASK =
        MAX_CHANNELS'((1 << CHANNEL_COUNT) - 1);

    logic                    s1_valid_reg, s1_valid_next;
    req_item_t               s1_item_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_item_reg;
    logic                    advance;
    logic                    req_take;

    logic                    tocr_reg, tocr_next;
    logic [MAX_CHANNELS-1:0] tstr_reg, tstr_next;
    logic [PRE_WIDTH-1:0]    pre_reg, pre_next;
    logic [DIV_COUNT-1:0]    div_edge;

    logic                    is_tick, is_read, is_write;
    chan_ctl_t               ch_ctl   [MAX_CHANNELS];
    logic [DATA_WIDTH-1:0]   rd_tcor  [MAX_CHANNELS];
    logic [DATA_WIDTH-1:0]   rd_tcnt  [MAX_CHANNELS];
    logic [DATA_WIDTH-1:0]   rd_tcr   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] irq_vec;
    logic [DATA_WIDTH-1:0]   read_value;

    // pipeline control
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_item_reg <= req;
        end
        if (advance)
        begin
            rsp_item_reg.read_data <= read_value;
            rsp_item_reg.irq_lines <= irq_vec;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    // decode of the transaction in the input register
    assign is_tick  = advance && (s1_item_reg.opcode == OP_TICK);
    assign is_read  = s1_item_reg.opcode == OP_READ;
    assign is_write = advance && (s1_item_reg.opcode == OP_WRITE);

    // prescaler, advanced by each tick transaction
    always_comb
    begin
        pre_next = pre_reg;
        if (is_tick)
        begin
            pre_next = pre_reg + 1'b1;
        end
        for (int d = 0; d < DIV_COUNT; d++)
        begin
            div_edge[d] = ((pre_reg + 1'b1) & DIV_MASK[d]) == '0;
        end
    end

    always_comb
    begin
        tocr_next = tocr_reg;
        tstr_next = tstr_reg;
        if (is_write && (s1_item_reg.reg_address == ADDR_TOCR))
        begin
            tocr_next = s1_item_reg.write_data[0];
        end
        if (is_write && (s1_item_reg.reg_address == ADDR_TSTR))
        begin
            tstr_next = s1_item_reg.write_data[MAX_CHANNELS-1:0] & START_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tocr_reg <= 1'b0;
            tstr_reg <= '0;
            pre_reg  <= '0;
        end
        else
        begin
            tocr_reg <= tocr_next;
            tstr_reg <= tstr_next;
            pre_reg  <= pre_next;
        end
    end

    // channels
    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_ch
        localparam logic [3:0] BASE = 4'(ADDR_CH_BASE + ADDR_CH_STEP * i);

        if (i < CHANNEL_COUNT)
        begin : g_on
            logic [COUNT_WIDTH-1:0] tcor;
            logic [COUNT_WIDTH-1:0] tcnt;
            logic [TCR_WIDTH-1:0]   tcr;
            logic                   irq;

            always_comb
            begin
                ch_ctl[i].tick     = is_tick;
                ch_ctl[i].start    = tstr_reg[i];
                ch_ctl[i].div_edge = div_edge;
                ch_ctl[i].wr_tcor  = is_write
                    && (s1_item_reg.reg_address == BASE + 4'(KIND_TCOR));
                ch_ctl[i].wr_tcnt  = is_write
                    && (s1_item_reg.reg_address == BASE + 4'(KIND_TCNT));
                ch_ctl[i].wr_tcr   = is_write
                    && (s1_item_reg.reg_address == BASE + 4'(KIND_TCR));
                ch_ctl[i].wr_data  = s1_item_reg.write_data;
            end

            tcrt_channel #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .HAS_CAPTURE (i == MAX_CHANNELS - 1)
            ) u_channel (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ch_ctl[i]),
                .tcor  (tcor),
                .tcnt  (tcnt),
                .tcr   (tcr),
                .irq   (irq)
            );

            assign rd_tcor[i] = DATA_WIDTH'(tcor);
            assign rd_tcnt[i] = DATA_WIDTH'(tcnt);
            assign rd_tcr[i]  = DATA_WIDTH'(tcr);
            assign irq_vec[i] = irq;
        end
        else
        begin : g_off
            assign ch_ctl[i]  = '0;
            assign rd_tcor[i] = '0;
            assign rd_tcnt[i] = '0;
            assign rd_tcr[i]  = '0;
            assign irq_vec[i] = 1'b0;
        end
    end

    // read mux, zero for ticks, writes, the unused opcode and unmapped addresses
    always_comb
    begin
        read_value = '0;
        if (is_read)
        begin
            if (s1_item_reg.reg_address == ADDR_TOCR)
            begin
                read_value = DATA_WIDTH'(tocr_reg);
            end
            else if (s1_item_reg.reg_address == ADDR_TSTR)
            begin
                read_value = DATA_WIDTH'(tstr_reg);
            end
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                if (s1_item_reg.reg_address == 4'(ADDR_CH_BASE + ADDR_CH_STEP * i + KIND_TCOR))
                begin
                    read_value = rd_tcor[i];
                end
                if (s1_item_reg.reg_address == 4'(ADDR_CH_BASE + ADDR_CH_STEP * i + KIND_TCNT))
                begin
                    read_value = rd_tcnt[i];
                end
                if (s1_item_reg.reg_address == 4'(ADDR_CH_BASE + ADDR_CH_STEP * i + KIND_TCR))
                begin
                    read_value = rd_tcr[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/tcrt_checker.sv
// ---------------------------------------------------------------------------
// tcrt_checker
// Port-level checks for the reload timer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tcrt_checker
    import tcrt_pkg::*;
#(
    parameter int unsigned CHANNEL_COUNT = 3
) (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    localparam logic [MAX_CHANNELS-1:0] ABSENT_MASK =
        ~MAX_CHANNELS'((1 << CHANNEL_COUNT) - 1);

    // a stalled result transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // with the result register empty the request side is never stalled
    a_no_stall_when_empty: assert property (@(posedge clk)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty result register");

    // an accepted transaction reaches the result side if it is not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
        else $error("accepted transaction did not produce a result");

    // channels that are not built never raise an interrupt
    a_absent_irq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.irq_lines & ABSENT_MASK) == '0)
        else $error("interrupt from an absent channel");

    // nothing is presented just after reset is sampled low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

endmodule

bind three_channel_reload_timer tcrt_checker #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
) u_tcrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

FILE: sim/tb_three_channel_reload_timer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_three_channel_reload_timer
// Self-checking bench for the three-channel reload timer. A shadow copy of
// the timer registers and prescaler predicts every response; requests and
// responses move with random valid gaps and stall bursts.
// ---------------------------------------------------------------------------

module tb_three_channel_reload_timer;
    import tcrt_pkg::*;

    localparam int unsigned N_CHANNELS    = 3;
    localparam int unsigned CNT_WIDTH     = 32;
    localparam int unsigned CAPTURE_CHAN  = 2;
    localparam logic [1:0]  OP_NONE       = 2'd3;
    localparam logic [3:0]  ADDR_TCPR2    = 4'd11;
    localparam logic [3:0]  ADDR_UNUSED_LO = 4'd12;
    localparam logic [3:0]  ADDR_UNUSED_HI = 4'd15;
    localparam int unsigned RANDOM_ITEMS  = 1200;
    localparam int unsigned SEGMENT_ITEMS = 100;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    localparam logic [TCR_WIDTH-1:0] TCR_UNIE = 10'h020;
    localparam logic [TCR_WIDTH-1:0] TCR_UNF  = 10'h100;

    class timer_register_shadow;
        rsp_item_t                 rsp_due_q[$];
        logic [2:0]                start_bits;
        logic                      output_enable;
        logic [DATA_WIDTH-1:0]     tcor[N_CHANNELS];
        logic [DATA_WIDTH-1:0]     tcnt[N_CHANNELS];
        logic [TCR_WIDTH-1:0]      tcr[N_CHANNELS];
        logic [PRE_WIDTH-1:0]      prescale;
        int unsigned               fail_count;
        int unsigned               checked_count;
        int unsigned               underflow_count;
        int unsigned               read_count;
        int unsigned               irq_count;

        function new();
            start_bits      = '0;
            output_enable   = 1'b0;
            prescale        = '0;
            fail_count      = 0;
            checked_count   = 0;
            underflow_count = 0;
            read_count      = 0;
            irq_count       = 0;
            for (int ch = 0; ch < N_CHANNELS; ch++)
            begin
                tcor[ch] = '1;
                tcnt[ch] = '1;
                tcr[ch]  = '0;
            end
        endfunction

        function void advance_tick();
            logic [2:0] tpsc;
            prescale = prescale + 1'b1;
            for (int ch = 0; ch < N_CHANNELS; ch++)
            begin
                tpsc = tcr[ch][2:0];
                if (start_bits[ch] && tpsc <= TPSC_MAX && (prescale & DIV_MASK[tpsc]) == '0)
                begin
                    if (tcnt[ch] == '0)
                    begin
                        tcnt[ch] = tcor[ch];
                        tcr[ch][UNF_POS] = 1'b1;
                        underflow_count++;
                    end
                    else
                    begin
                        tcnt[ch] = tcnt[ch] - 1'b1;
                    end
                end
            end
        endfunction

        function logic [DATA_WIDTH-1:0] read_reg(logic [3:0] addr);
            int unsigned ch;
            int unsigned kind;
            if (addr == ADDR_TOCR)
                return {{(DATA_WIDTH-1){1'b0}}, output_enable};
            if (addr == ADDR_TSTR)
                return {{(DATA_WIDTH-3){1'b0}}, start_bits};
            if (addr < ADDR_CH_BASE || addr >= ADDR_CH_BASE + ADDR_CH_STEP * MAX_CHANNELS)
                return '0;
            ch   = (addr - ADDR_CH_BASE) / ADDR_CH_STEP;
            kind = (addr - ADDR_CH_BASE) % ADDR_CH_STEP;
            if (ch >= N_CHANNELS)
                return '0;
            if (kind == KIND_TCOR)
                return tcor[ch];
            if (kind == KIND_TCNT)
                return tcnt[ch];
            return {{(DATA_WIDTH-TCR_WIDTH){1'b0}}, tcr[ch]};
        endfunction

        function void write_reg(logic [3:0] addr, logic [DATA_WIDTH-1:0] data);
            int unsigned ch;
            int unsigned kind;
            logic [TCR_WIDTH-1:0] keep;
            logic [TCR_WIDTH-1:0] mask;
            if (addr == ADDR_TOCR)
            begin
                output_enable = data[0];
                return;
            end
            if (addr == ADDR_TSTR)
            begin
                start_bits = data[2:0];
                return;
            end
            if (addr < ADDR_CH_BASE || addr >= ADDR_CH_BASE + ADDR_CH_STEP * MAX_CHANNELS)
                return;
            ch   = (addr - ADDR_CH_BASE) / ADDR_CH_STEP;
            kind = (addr - ADDR_CH_BASE) % ADDR_CH_STEP;
            if (ch >= N_CHANNELS)
                return;
            if (kind == KIND_TCOR)
                tcor[ch] = data;
            else if (kind == KIND_TCNT)
                tcnt[ch] = data;
            else
            begin
                // flags only survive a write of one, never get set by it
                keep    = tcr[ch] & data[TCR_WIDTH-1:0] & TCR_FLAGS;
                mask    = (ch == CAPTURE_CHAN) ? TCR_MASK_CAPTURE : TCR_MASK_PLAIN;
                tcr[ch] = ((data[TCR_WIDTH-1:0] & ~TCR_FLAGS) | keep) & mask;
            end
        endfunction

        function void log_request(req_item_t item);
            rsp_item_t due;
            due = '0;
            case (item.opcode)
                OP_TICK:  advance_tick();
                OP_READ:
                begin
                    due.read_data = read_reg(item.reg_address);
                    read_count++;
                end
                OP_WRITE: write_reg(item.reg_address, item.write_data);
                default: ;
            endcase
            for (int ch = 0; ch < N_CHANNELS; ch++)
                due.irq_lines[ch] = tcr[ch][UNF_POS] & tcr[ch][UNIE_POS];
            if (due.irq_lines != '0)
                irq_count++;
            rsp_due_q.push_back(due);
        endfunction

        function void compare_response(rsp_item_t got);
            rsp_item_t due;
            if (rsp_due_q.size() == 0)
            begin
                $error("unexpected response read_data=%h irq_lines=%b",
                       got.read_data, got.irq_lines);
                fail_count++;
                return;
            end
            due = rsp_due_q.pop_front();
            checked_count++;
            if (got.read_data !== due.read_data)
            begin
                $error("read_data mismatch: expected %h, actual %h",
                       due.read_data, got.read_data);
                fail_count++;
            end
            if (got.irq_lines !== due.irq_lines)
            begin
                $error("irq_lines mismatch: expected %b, actual %b",
                       due.irq_lines, got.irq_lines);
                fail_count++;
            end
        endfunction

        function int unsigned outstanding();
            return rsp_due_q.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    timer_register_shadow shadow;
    int unsigned          cycle_count = 0;
    int unsigned          sent_count  = 0;
    int unsigned          req_gap_pct = 0;
    int unsigned          rsp_stall_pct = 0;
    int unsigned          stall_left  = 0;

    three_channel_reload_timer #(
        .CHANNEL_COUNT (N_CHANNELS),
        .COUNT_WIDTH   (CNT_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL three_channel_reload_timer");
            $finish;
        end
    end

    // result side backpressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.compare_response(rsp);
    end

    function automatic logic [3:0] chan_addr(int unsigned ch, int unsigned kind);
        return 4'(ADDR_CH_BASE + ADDR_CH_STEP * ch + kind);
    endfunction

    function automatic req_item_t make_item(logic [1:0] op, logic [3:0] addr,
                                            logic [DATA_WIDTH-1:0] data);
        req_item_t item;
        item.opcode      = op;
        item.reg_address = addr;
        item.write_data  = data;
        return item;
    endfunction

    task automatic send_item(input req_item_t item);
        if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        shadow.log_request(item);
        sent_count++;
    endtask

    task automatic send_tick();
        send_item(make_item(OP_TICK, 4'($urandom_range(0, 15)), $urandom()));
    endtask

    task automatic send_read(input logic [3:0] addr);
        send_item(make_item(OP_READ, addr, $urandom()));
    endtask

    task automatic send_write(input logic [3:0] addr, input logic [DATA_WIDTH-1:0] data);
        send_item(make_item(OP_WRITE, addr, data));
    endtask

    // count-like registers get small values most of the time so underflows happen
    function automatic logic [DATA_WIDTH-1:0] count_value();
        if ($urandom_range(0, 9) < 7)
            return DATA_WIDTH'($urandom_range(0, 15));
        return $urandom();
    endfunction

    function automatic logic [DATA_WIDTH-1:0] control_value();
        logic [DATA_WIDTH-1:0] data;
        data = $urandom();
        case ($urandom_range(0, 3))
            0, 1: data[2:0] = 3'd0;
            2:    data[2:0] = 3'd1;
            default: ;
        endcase
        data[UNIE_POS] = ($urandom_range(0, 3) != 0);
        return data;
    endfunction

    function automatic req_item_t random_item();
        int unsigned           pick;
        int unsigned           ch;
        int unsigned           kind;
        logic [3:0]            addr;
        logic [DATA_WIDTH-1:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return make_item(OP_TICK, 4'($urandom_range(0, 15)), $urandom());
        if (pick < 70)
        begin
            addr = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(ADDR_UNUSED_LO, ADDR_UNUSED_HI))
                                              : 4'($urandom_range(0, ADDR_TCPR2));
            return make_item(OP_READ, addr, $urandom());
        end
        if (pick < 97)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    addr = ADDR_TOCR;
                    data = $urandom();
                end
                1, 2:
                begin
                    addr = ADDR_TSTR;
                    data = ($urandom_range(0, 3) == 0) ? $urandom() : DATA_WIDTH'(7);
                end
                9:
                begin
                    addr = 4'($urandom_range(0, 15));
                    data = $urandom();
                end
                default:
                begin
                    ch   = $urandom_range(0, N_CHANNELS - 1);
                    kind = $urandom_range(0, ADDR_CH_STEP - 1);
                    addr = chan_addr(ch, kind);
                    data = (kind == KIND_TCR) ? control_value() : count_value();
                end
            endcase
            return make_item(OP_WRITE, addr, data);
        end
        return make_item(OP_NONE, 4'($urandom_range(0, 15)), $urandom());
    endfunction

    initial
    begin
        shadow = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values, register widths and the capture-only control bits
        send_read(ADDR_TOCR);
        send_read(chan_addr(2, KIND_TCNT));
        send_write(ADDR_TOCR, '1);
        send_read(ADDR_TOCR);
        send_write(chan_addr(CAPTURE_CHAN, KIND_TCR), '1);
        send_read(chan_addr(CAPTURE_CHAN, KIND_TCR));
        send_write(chan_addr(0, KIND_TCR), '1);
        send_write(ADDR_TSTR, '1);
        // prescaler select 7 is unsupported, channel 0 must not move
        send_tick();
        send_read(chan_addr(0, KIND_TCNT));
        send_write(chan_addr(0, KIND_TCNT), '0);
        send_write(chan_addr(0, KIND_TCOR), DATA_WIDTH'(5));
        send_write(chan_addr(0, KIND_TCR), DATA_WIDTH'(TCR_UNIE));
        // the ticks below reach a divide-by-4 edge: underflow from zero
        repeat (3) send_tick();
        send_read(chan_addr(0, KIND_TCR));
        send_write(chan_addr(0, KIND_TCR), DATA_WIDTH'(TCR_UNF | TCR_UNIE));
        send_write(chan_addr(0, KIND_TCR), '0);
        send_read(ADDR_TCPR2);
        send_write(ADDR_TCPR2, '1);
        send_read(ADDR_UNUSED_HI);
        send_write(ADDR_UNUSED_LO, '1);
        send_item(make_item(OP_NONE, ADDR_TSTR, '1));
        send_write(ADDR_TSTR, '0);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % SEGMENT_ITEMS == 0)
            begin
                if (n >= RANDOM_ITEMS - 2 * SEGMENT_ITEMS)
                begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: req_gap_pct = 0;
                        1: req_gap_pct = 10;
                        default: req_gap_pct = 40;
                    endcase
                    case ($urandom_range(0, 2))
                        0: rsp_stall_pct = 0;
                        1: rsp_stall_pct = 10;
                        default: rsp_stall_pct = 40;
                    endcase
                end
            end
            send_item(random_item());
        end
        req_valid <= 1'b0;

        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d transactions sent, %0d responses checked, %0d register reads",
                 sent_count, shadow.checked_count, shadow.read_count);
        $display("%0d counter underflows seen, %0d responses with an interrupt raised",
                 shadow.underflow_count, shadow.irq_count);
        if (shadow.fail_count == 0)
            $display("PASS three_channel_reload_timer");
        else
            $display("FAIL three_channel_reload_timer");
        $finish;
    end

endmodule
